/* design/fpa_pkg.sv */
`timescale 1ns / 1ps
// fpa_pkg: shared constants, controller states and control structs
// for the flash page assembler; no dependencies

package fpa_pkg;

    localparam int unsigned FPA_PAGE_BYTES = 256;
    localparam logic [7:0]  ERASED_BYTE    = 8'hFF;
    localparam int unsigned ADDR_W         = 32;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned WORD_W         = 64;
    localparam int unsigned WIDX_W         = 5;
    localparam int unsigned IN_DATA_W      = 40;
    localparam int unsigned OUT_DATA_W     = 104;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_APPLY
    } fpa_state_t;

    // controller to datapath
    typedef struct packed {
        logic take;   // accept item and apply it at once
        logic hold;   // accept item and keep it until the last page word is loaded
        logic rd;     // read page memory at the word counter
        logic ld;     // load the output register
        logic next;   // advance the word counter
        logic apply;  // apply the held item
    } fpa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit_needed;
        logic out_free;
        logic last_word;
    } fpa_status_t;

endpackage

/* design/fpa_ctrl.sv */
`timescale 1ns / 1ps
// fpa_ctrl: controller state machine of the flash page assembler
// depends on fpa_pkg

module fpa_ctrl
    import fpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  fpa_status_t status,
    output fpa_cmd_t    cmd
);

    fpa_state_t state_reg;
    fpa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (status.emit_needed)
                    begin
                        cmd.hold   = 1'b1;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        cmd.take = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.ld = 1'b1;
                    if (status.last_word)
                    begin
                        state_next = ST_APPLY;
                    end
                    else
                    begin
                        cmd.next   = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/fpa_datapath.sv */
`timescale 1ns / 1ps
// fpa_datapath: page memory, page base, held item, word counter and output register
// depends on fpa_pkg

module fpa_datapath
    import fpa_pkg::*;
#(
    parameter int unsigned PAGE_BYTES = FPA_PAGE_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_func,
    input  logic [ADDR_W-1:0]     in_addr,
    input  logic [BYTE_W-1:0]     in_data,
    input  fpa_cmd_t              cmd,
    output fpa_status_t           status,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [ADDR_W-1:0]     out_page_address,
    output logic [WIDX_W-1:0]     out_word_index,
    output logic [WORD_W-1:0]     out_page_word,
    output logic                  out_last_word
);

    localparam int unsigned PAGE_WORDS = PAGE_BYTES / 8;
    localparam int unsigned PB         = $clog2(PAGE_BYTES);
    localparam int unsigned CW         = (PAGE_WORDS > 1) ? $clog2(PAGE_WORDS) : 1;
    localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);
    localparam logic [CW-1:0]     LAST_IDX  = CW'(PAGE_WORDS - 1);

    logic [WORD_W-1:0]      mem [PAGE_WORDS];
    logic [PAGE_WORDS-1:0]  row_valid_reg;
    logic [PAGE_WORDS-1:0]  row_valid_next;
    logic [ADDR_W-1:0]      base_reg;
    logic [ADDR_W-1:0]      base_next;
    logic                   has_data_reg;
    logic                   has_data_next;

    logic                   hold_func_reg;
    logic [ADDR_W-1:0]      hold_addr_reg;
    logic [BYTE_W-1:0]      hold_data_reg;

    logic [CW-1:0]          cnt_reg;
    logic [WORD_W-1:0]      rd_word_reg;
    logic                   rd_hit_reg;

    logic                   out_valid_reg;
    logic [ADDR_W-1:0]      out_addr_reg;
    logic [WIDX_W-1:0]      out_idx_reg;
    logic [WORD_W-1:0]      out_word_reg;
    logic                   out_last_reg;

    logic                   u_en;
    logic                   u_func;
    logic [ADDR_W-1:0]      u_addr;
    logic [BYTE_W-1:0]      u_data;
    logic [CW-1:0]          u_row;
    logic [2:0]             u_lane;
    logic                   u_gt;
    logic                   u_eq;
    logic                   clear_all;
    logic                   wr_en;
    logic                   row_v;

    assign u_en   = cmd.take | cmd.apply;
    assign u_func = cmd.apply ? hold_func_reg : in_func;
    assign u_addr = cmd.apply ? hold_addr_reg : in_addr;
    assign u_data = cmd.apply ? hold_data_reg : in_data;
    assign u_lane = u_addr[2:0];

    generate
        if (PAGE_WORDS > 1)
        begin : g_row
            assign u_row = u_addr[PB-1:3];
        end
        else
        begin : g_row_one
            assign u_row = '0;
        end
    endgenerate

    assign u_gt      = u_addr[ADDR_W-1:PB] > base_reg[ADDR_W-1:PB];
    assign u_eq      = u_addr[ADDR_W-1:PB] == base_reg[ADDR_W-1:PB];
    assign clear_all = u_en && (u_func || u_gt);
    assign wr_en     = u_en && !u_func && (u_gt || u_eq);
    assign row_v     = !clear_all && row_valid_reg[u_row];

    always_comb
    begin
        base_next      = base_reg;
        has_data_next  = has_data_reg;
        row_valid_next = clear_all ? '0 : row_valid_reg;
        if (u_en && u_func)
        begin
            base_next     = '0;
            has_data_next = 1'b0;
        end
        else if (u_en && u_gt)
        begin
            base_next = u_addr & ~PAGE_MASK;
        end
        if (wr_en)
        begin
            has_data_next         = 1'b1;
            row_valid_next[u_row] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            has_data_reg  <= 1'b0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg      <= base_next;
            has_data_reg  <= has_data_next;
            row_valid_reg <= row_valid_next;
            if (cmd.ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // page memory: byte lane write, full row of erased bytes on first touch
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int l = 0; l < 8; l++)
            begin
                if (u_lane == 3'(l))
                begin
                    mem[u_row][8*l +: 8] <= u_data;
                end
                else if (!row_v)
                begin
                    mem[u_row][8*l +: 8] <= ERASED_BYTE;
                end
            end
        end
        if (cmd.rd)
        begin
            rd_word_reg <= mem[cnt_reg];
            rd_hit_reg  <= row_valid_reg[cnt_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hold)
        begin
            hold_func_reg <= in_func;
            hold_addr_reg <= in_addr;
            hold_data_reg <= in_data;
            cnt_reg       <= '0;
        end
        else if (cmd.next)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.ld)
        begin
            out_addr_reg <= base_reg;
            out_idx_reg  <= WIDX_W'(cnt_reg);
            out_word_reg <= rd_hit_reg ? rd_word_reg : {8{ERASED_BYTE}};
            out_last_reg <= (cnt_reg == LAST_IDX);
        end
    end

    assign status.emit_needed = has_data_reg &&
                                (in_func || (in_addr[ADDR_W-1:PB] > base_reg[ADDR_W-1:PB]));
    assign status.out_free    = !out_valid_reg || out_ready;
    assign status.last_word   = (cnt_reg == LAST_IDX);

    assign out_valid        = out_valid_reg;
    assign out_page_address = out_addr_reg;
    assign out_word_index   = out_idx_reg;
    assign out_page_word    = out_word_reg;
    assign out_last_word    = out_last_reg;

endmodule

/* design/flash_page_assembler_top.sv */
`timescale 1ns / 1ps
// flash_page_assembler_top: top level, joins fpa_ctrl and fpa_datapath
// depends on fpa_pkg, fpa_ctrl, fpa_datapath
// an item that emits no page is taken at once; one that flushes a page blocks further input
// while each page word passes the read and load states through the single page memory read
// port, longer while the output stalls; the first word goes through the read register into
// the output register; rst_n clears control, page base and row valid bits at once, no sweep

module flash_page_assembler_top
    import fpa_pkg::*;
#(
    parameter int unsigned PAGE_BYTES = FPA_PAGE_BYTES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // byte_address, data_byte
    input  logic                   s_axis_tuser,   // func
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // page_address, word_index, page_word, zero pad
    output logic                   m_axis_tlast
);

    fpa_cmd_t          cmd;
    fpa_status_t       status;
    logic [ADDR_W-1:0] page_address;
    logic [WIDX_W-1:0] word_index;
    logic [WORD_W-1:0] page_word;

    fpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fpa_datapath #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_func          (s_axis_tuser),
        .in_addr          (s_axis_tdata[ADDR_W-1:0]),
        .in_data          (s_axis_tdata[ADDR_W +: BYTE_W]),
        .cmd              (cmd),
        .status           (status),
        .out_ready        (m_axis_tready),
        .out_valid        (m_axis_tvalid),
        .out_page_address (page_address),
        .out_word_index   (word_index),
        .out_page_word    (page_word),
        .out_last_word    (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - ADDR_W - WIDX_W - WORD_W){1'b0}},
                           page_word, word_index, page_address};

endmodule

/* design/fpa_checker.sv */
`timescale 1ns / 1ps
// fpa_checker: port level assertions for flash_page_assembler_top, bound to it
// depends on fpa_pkg and flash_page_assembler_top

module fpa_checker
    import fpa_pkg::*;
#(
    parameter int unsigned PAGE_BYTES = FPA_PAGE_BYTES
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input logic                   m_axis_tlast
);

    localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);
    localparam logic [WIDX_W-1:0] LAST_IDX  = WIDX_W'(PAGE_BYTES / 8 - 1);

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_data_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_page_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[ADDR_W-1:0] & PAGE_MASK) == '0)
        else $error("page address not aligned");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[ADDR_W +: WIDX_W] == LAST_IDX)))
        else $error("tlast does not match final word index");

    a_busy_mid_page: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken while a page is still going out");

endmodule

bind flash_page_assembler_top fpa_checker #(.PAGE_BYTES(PAGE_BYTES)) u_fpa_checker (.*);
